// ===== rtl/pid_pkg.sv =====
// Shared types, register indexes, reset values and saturation helpers for the PID step.
package pid_pkg;

   localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
   localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

   localparam logic [2:0] CSR_KP            = 3'd0;
   localparam logic [2:0] CSR_KI            = 3'd1;
   localparam logic [2:0] CSR_KD            = 3'd2;
   localparam logic [2:0] CSR_FILTER_TIME   = 3'd3;
   localparam logic [2:0] CSR_SAMPLE_PERIOD = 3'd4;
   localparam logic [2:0] CSR_OUT_MIN       = 3'd5;
   localparam logic [2:0] CSR_OUT_MAX       = 3'd6;

   localparam logic signed [31:0] KP_RESET            = 32'sd65536;
   localparam logic signed [31:0] KI_RESET            = 32'sd0;
   localparam logic signed [31:0] KD_RESET            = 32'sd0;
   localparam logic [30:0]        FILTER_TIME_RESET   = 31'd0;
   localparam logic [30:0]        SAMPLE_PERIOD_RESET = 31'd655;

   typedef struct packed {
      logic signed [32:0] a;
      logic signed [32:0] b;
   } mul_op_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [32:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

   function automatic logic signed [31:0] sat_s34(input logic signed [33:0] x);
      logic signed [31:0] r;
      if (x[33:31] == 3'b000 || x[33:31] == 3'b111) begin
         r = x[31:0];
      end else if (x[33]) begin
         r = S32_MIN;
      end else begin
         r = S32_MAX;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] q16_sat(input logic signed [65:0] prod);
      logic signed [65:0] s;
      logic signed [31:0] r;
      s = prod >>> 16;
      if (s[65:31] == 35'h0 || s[65:31] == {35{1'b1}}) begin
         r = s[31:0];
      end else if (s[65]) begin
         r = S32_MIN;
      end else begin
         r = S32_MAX;
      end
      return r;
   endfunction

   function automatic logic signed [63:0] sat_s66(input logic signed [65:0] x);
      logic signed [63:0] r;
      if (x[65:63] == 3'b000 || x[65:63] == 3'b111) begin
         r = x[63:0];
      end else if (x[65]) begin
         r = S64_MIN;
      end else begin
         r = S64_MAX;
      end
      return r;
   endfunction

endpackage

// ===== rtl/pid_mul.sv =====
// Shared signed 33 by 33 multiplier with a registered product.
module pid_mul
   import pid_pkg::*;
(
   input  logic               clock,
   input  mul_op_type         op,
   output logic signed [65:0] prod
);

   logic signed [65:0] prod_ff;
   logic signed [65:0] prod_in;

   assign prod_in = $signed(op.a) * $signed(op.b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== rtl/pid_div.sv =====
// Iterative restoring divider, one quotient bit per cycle, saturating to 32 bits.
module pid_div
   import pid_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output div_rsp_type rsp
);

   localparam logic [1:0] D_IDLE  = 2'd0;
   localparam logic [1:0] D_CHECK = 2'd1;
   localparam logic [1:0] D_ITER  = 2'd2;
   localparam logic [1:0] D_FIN   = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] low_ff, low_in;
   logic [32:0] den_ff, den_in;
   logic        done_ff, done_in;
   logic [31:0] quo_ff, quo_in;

   logic [63:0] mag;
   logic [33:0] shifted;
   logic [33:0] diff;

   assign mag     = req.dividend[63] ? (64'd0 - req.dividend) : req.dividend;
   assign shifted = {rem_ff, low_ff[31]};
   assign diff    = shifted - {1'b0, den_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      den_in   = den_ff;
      done_in  = 1'b0;
      quo_in   = quo_ff;
      case (state_ff)
         D_IDLE: begin
            if (req.start) begin
               neg_in   = req.dividend[63];
               rem_in   = {1'b0, mag[63:32]};
               low_in   = mag[31:0];
               den_in   = req.divisor;
               cnt_in   = 5'd0;
               state_in = D_CHECK;
            end
         end
         D_CHECK: begin
            if (den_ff == 33'd0) begin
               quo_in   = 32'd0;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else if (rem_ff >= den_ff) begin
               quo_in   = neg_ff ? S32_MIN : S32_MAX;
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               state_in = D_ITER;
            end
         end
         D_ITER: begin
            if (!diff[33]) begin
               rem_in = diff[32:0];
               low_in = {low_ff[30:0], 1'b1};
            end else begin
               rem_in = shifted[32:0];
               low_in = {low_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               state_in = D_FIN;
            end
         end
         D_FIN: begin
            if (neg_ff) begin
               if (low_ff > 32'h8000_0000) begin
                  quo_in = S32_MIN;
               end else begin
                  quo_in = 32'd0 - low_ff;
               end
            end else if (low_ff[31]) begin
               quo_in = S32_MAX;
            end else begin
               quo_in = low_ff;
            end
            done_in  = 1'b1;
            state_in = D_IDLE;
         end
         default: begin
            state_in = D_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      rem_ff <= rem_in;
      low_ff <= low_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;

endmodule

// ===== rtl/pid_controller_step.sv =====
// PID step top level: registers, state, sequencer over the shared multiplier and divider.
//
//   channel   ports                             direction   word
//   req       req_valid/req_ready               in          req_target, req_sensed
//   rsp       rsp_valid/rsp_ready               out         rsp_drive
//   csr       csr_write_en/csr_index/csr_wdata  in          one register per write
//
// A new word is accepted only once the last has left the sequencer; the time per word is set by
// the 32 one-bit steps of the divider that forms the filtered derivative; when the quotient
// saturates or the divisor is zero the divider stops early.
// Reset clears the state and loads the register defaults.
// A finished word waits in the output register; a new word is accepted meanwhile, and
// the sequencer holds its next result until the output register is free.
module pid_controller_step
   import pid_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_target,
   input  logic signed [31:0] req_sensed,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_drive,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_MUL_P    = 4'd1;
   localparam logic [3:0] ST_MUL_KT   = 4'd2;
   localparam logic [3:0] ST_MUL_DM   = 4'd3;
   localparam logic [3:0] ST_MUL_I    = 4'd4;
   localparam logic [3:0] ST_MUL_D    = 4'd5;
   localparam logic [3:0] ST_NUM      = 4'd6;
   localparam logic [3:0] ST_DIV      = 4'd7;
   localparam logic [3:0] ST_DIV_WAIT = 4'd8;
   localparam logic [3:0] ST_SUM      = 4'd9;
   localparam logic [3:0] ST_OUT      = 4'd10;

   logic signed [31:0] kp_ff, ki_ff, kd_ff, out_min_ff, out_max_ff;
   logic [30:0]        filter_time_ff, sample_period_ff;

   logic [3:0]         state_ff, state_in;
   logic signed [31:0] iacc_ff, iacc_in;
   logic signed [31:0] last_err_ff, last_err_in;
   logic signed [31:0] deriv_ff, deriv_in;
   logic signed [31:0] last_sensed_ff, last_sensed_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic signed [31:0] err_ff, err_in;
   logic signed [31:0] dm_ff, dm_in;
   logic signed [31:0] avg_ff, avg_in;
   logic signed [32:0] coef_ff, coef_in;
   logic [32:0]        den_ff, den_in;
   logic signed [31:0] p_ff, p_in;
   logic signed [31:0] kt_ff, kt_in;
   logic signed [31:0] hi_ff, hi_in;
   logic signed [31:0] lo_ff, lo_in;
   logic signed [65:0] num_ff, num_in;
   logic signed [63:0] dvd_ff, dvd_in;
   logic signed [31:0] drv_ff, drv_in;
   logic signed [31:0] rsp_drive_ff, rsp_drive_in;

   mul_op_type         mul_op;
   logic signed [65:0] prod;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   logic signed [32:0] avg_sum;
   logic signed [31:0] integ_step;
   logic signed [31:0] clamped;
   logic               out_free;

   pid_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod)
   );

   pid_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_drive = rsp_drive_ff;

   assign div_req.start    = (state_ff == ST_DIV);
   assign div_req.dividend = dvd_ff;
   assign div_req.divisor  = den_ff;

   assign avg_sum    = {err_ff[31], err_ff} + {last_err_ff[31], last_err_ff};
   assign integ_step = q16_sat(prod);
   assign out_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      if (drv_ff > out_max_ff) begin
         clamped = out_max_ff;
      end else if (drv_ff < out_min_ff) begin
         clamped = out_min_ff;
      end else begin
         clamped = drv_ff;
      end
   end

   always_comb begin
      case (state_ff)
         ST_MUL_P: begin
            mul_op.a = {kp_ff[31], kp_ff};
            mul_op.b = {err_ff[31], err_ff};
         end
         ST_MUL_KT: begin
            mul_op.a = {ki_ff[31], ki_ff};
            mul_op.b = {2'b00, sample_period_ff};
         end
         ST_MUL_DM: begin
            mul_op.a = {kd_ff[31], kd_ff};
            mul_op.b = {dm_ff[31], dm_ff};
         end
         ST_MUL_I: begin
            mul_op.a = {kt_ff[31], kt_ff};
            mul_op.b = {avg_ff[31], avg_ff};
         end
         ST_MUL_D: begin
            mul_op.a = coef_ff;
            mul_op.b = {deriv_ff[31], deriv_ff};
         end
         default: begin
            mul_op.a = 33'sd0;
            mul_op.b = 33'sd0;
         end
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      iacc_in        = iacc_ff;
      last_err_in    = last_err_ff;
      deriv_in       = deriv_ff;
      last_sensed_in = last_sensed_ff;
      err_in         = err_ff;
      dm_in          = dm_ff;
      avg_in         = avg_ff;
      coef_in        = coef_ff;
      den_in         = den_ff;
      p_in           = p_ff;
      kt_in          = kt_ff;
      hi_in          = hi_ff;
      lo_in          = lo_ff;
      num_in         = num_ff;
      dvd_in         = dvd_ff;
      drv_in         = drv_ff;
      rsp_drive_in   = rsp_drive_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               err_in = sat_s34({{2{req_target[31]}}, req_target}
                                - {{2{req_sensed[31]}}, req_sensed});
               dm_in = sat_s34({{2{req_sensed[31]}}, req_sensed}
                               - {{2{last_sensed_ff[31]}}, last_sensed_ff});
               last_sensed_in = req_sensed;
               state_in       = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            avg_in   = avg_sum[32:1];
            coef_in  = $signed({1'b0, filter_time_ff, 1'b0})
                       - $signed({2'b00, sample_period_ff});
            den_in   = {1'b0, filter_time_ff, 1'b0} + {2'b00, sample_period_ff};
            state_in = ST_MUL_KT;
         end
         ST_MUL_KT: begin
            p_in     = q16_sat(prod);
            state_in = ST_MUL_DM;
         end
         ST_MUL_DM: begin
            kt_in = q16_sat(prod);
            if (out_max_ff > p_ff) begin
               hi_in = sat_s34({{2{out_max_ff[31]}}, out_max_ff} - {{2{p_ff[31]}}, p_ff});
            end else begin
               hi_in = 32'sd0;
            end
            if (out_min_ff < p_ff) begin
               lo_in = sat_s34({{2{out_min_ff[31]}}, out_min_ff} - {{2{p_ff[31]}}, p_ff});
            end else begin
               lo_in = 32'sd0;
            end
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            num_in   = 66'sd0 - (prod <<< 1);
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            iacc_in  = sat_s34({{2{iacc_ff[31]}}, iacc_ff}
                               + {{2{integ_step[31]}}, integ_step});
            state_in = ST_NUM;
         end
         ST_NUM: begin
            dvd_in = sat_s66(num_ff + prod);
            if (iacc_ff > hi_ff) begin
               iacc_in = hi_ff;
            end else if (iacc_ff < lo_ff) begin
               iacc_in = lo_ff;
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               deriv_in = div_rsp.quotient;
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            drv_in   = sat_s34({{2{p_ff[31]}}, p_ff} + {{2{iacc_ff[31]}}, iacc_ff}
                               + {{2{deriv_ff[31]}}, deriv_ff});
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_drive_in = clamped;
               rsp_valid_in = 1'b1;
               last_err_in  = err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff            <= KP_RESET;
         ki_ff            <= KI_RESET;
         kd_ff            <= KD_RESET;
         filter_time_ff   <= FILTER_TIME_RESET;
         sample_period_ff <= SAMPLE_PERIOD_RESET;
         out_min_ff       <= S32_MIN;
         out_max_ff       <= S32_MAX;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_KP:            kp_ff            <= csr_wdata;
            CSR_KI:            ki_ff            <= csr_wdata;
            CSR_KD:            kd_ff            <= csr_wdata;
            CSR_FILTER_TIME:   filter_time_ff   <= csr_wdata[30:0];
            CSR_SAMPLE_PERIOD: sample_period_ff <= csr_wdata[30:0];
            CSR_OUT_MIN:       out_min_ff       <= csr_wdata;
            CSR_OUT_MAX:       out_max_ff       <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         iacc_ff        <= 32'sd0;
         last_err_ff    <= 32'sd0;
         deriv_ff       <= 32'sd0;
         last_sensed_ff <= 32'sd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         iacc_ff        <= iacc_in;
         last_err_ff    <= last_err_in;
         deriv_ff       <= deriv_in;
         last_sensed_ff <= last_sensed_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      err_ff       <= err_in;
      dm_ff        <= dm_in;
      avg_ff       <= avg_in;
      coef_ff      <= coef_in;
      den_ff       <= den_in;
      p_ff         <= p_in;
      kt_ff        <= kt_in;
      hi_ff        <= hi_in;
      lo_ff        <= lo_in;
      num_ff       <= num_in;
      dvd_ff       <= dvd_in;
      drv_ff       <= drv_in;
      rsp_drive_ff <= rsp_drive_in;
   end

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for pid_controller_step: random gains and trajectories vs a predictor.
`timescale 1ns / 1ps

module testbench
   import pid_pkg::*;
();

   localparam logic [2:0] CSR_UNUSED  = 3'd7;
   localparam int         CYCLE_LIMIT = 600000;
   localparam int         HOLD_CYCLES = 700;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic signed [31:0] target;
      logic signed [31:0] sensed;
   } setpoint_word_type;

   logic               clock;
   logic               reset        = 1'b1;
   logic               req_valid    = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_target   = '0;
   logic signed [31:0] req_sensed   = '0;
   logic               rsp_valid;
   logic               rsp_ready    = 1'b0;
   logic signed [31:0] rsp_drive;
   logic               csr_write_en = 1'b0;
   logic [2:0]         csr_index    = '0;
   logic [31:0]        csr_wdata    = '0;

   setpoint_word_type  pending_words[$];
   logic signed [31:0] predicted_drive[$];

   logic signed [31:0] gain_p        = KP_RESET;
   logic signed [31:0] gain_i        = KI_RESET;
   logic signed [31:0] gain_d        = KD_RESET;
   logic [30:0]        tau_q         = FILTER_TIME_RESET;
   logic [30:0]        period_q      = SAMPLE_PERIOD_RESET;
   logic signed [31:0] drive_floor   = S32_MIN;
   logic signed [31:0] drive_ceiling = S32_MAX;
   logic signed [31:0] integ_state   = '0;
   logic signed [31:0] prev_error    = '0;
   logic signed [31:0] deriv_state   = '0;
   logic signed [31:0] prev_sensed   = '0;

   int   error_count = 0;
   int   send_mode   = 0;
   int   recv_mode   = 0;
   int   send_gap    = 0;
   int   recv_wait   = 0;
   int   recv_next;
   int   cycle_count;
   logic rsp_hold    = 1'b0;

   pid_controller_step dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_target   (req_target),
      .req_sensed   (req_sensed),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_drive    (rsp_drive),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic wide_type clamp_s32(input wide_type x);
      wide_type r;
      wide_type top;
      wide_type bottom;
      top    = S32_MAX;
      bottom = S32_MIN;
      if (x > top) begin
         r = top;
      end else if (x < bottom) begin
         r = bottom;
      end else begin
         r = x;
      end
      return r;
   endfunction

   function automatic wide_type clamp_s64(input wide_type x);
      wide_type r;
      wide_type top;
      wide_type bottom;
      top    = S64_MAX;
      bottom = S64_MIN;
      if (x > top) begin
         r = top;
      end else if (x < bottom) begin
         r = bottom;
      end else begin
         r = x;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] pid_predict_drive(input logic signed [31:0] target,
                                                            input logic signed [31:0] sensed);
      wide_type t_w, s_w, kp_w, ki_w, kd_w, tau_w, per_w, min_w, max_w;
      wide_type prev_e_w, prev_s_w, integ, deriv_w;
      wide_type err, p, kt, avg, hi, lo, dm, t1, t2, num, den, d, drv;
      t_w      = target;
      s_w      = sensed;
      kp_w     = gain_p;
      ki_w     = gain_i;
      kd_w     = gain_d;
      tau_w    = tau_q;
      per_w    = period_q;
      min_w    = drive_floor;
      max_w    = drive_ceiling;
      prev_e_w = prev_error;
      prev_s_w = prev_sensed;
      integ    = integ_state;
      deriv_w  = deriv_state;

      err   = clamp_s32(t_w - s_w);
      p     = clamp_s32((kp_w * err) >>> 16);
      kt    = clamp_s32((ki_w * per_w) >>> 16);
      avg   = (err + prev_e_w) >>> 1;
      integ = clamp_s32(integ + clamp_s32((kt * avg) >>> 16));

      // Integrator limits follow the output limits minus the proportional term.
      hi = (max_w > p) ? clamp_s32(max_w - p) : 0;
      lo = (min_w < p) ? clamp_s32(min_w - p) : 0;
      if (integ > hi) begin
         integ = hi;
      end else if (integ < lo) begin
         integ = lo;
      end

      dm  = clamp_s32(s_w - prev_s_w);
      t1  = -(kd_w * dm) * 2;
      t2  = (2 * tau_w - per_w) * deriv_w;
      num = clamp_s64(t1 + t2);
      den = 2 * tau_w + per_w;
      d   = (den == 0) ? 0 : clamp_s32(num / den);

      drv = clamp_s32(p + integ + d);
      if (drv > max_w) begin
         drv = max_w;
      end else if (drv < min_w) begin
         drv = min_w;
      end

      integ_state = integ[31:0];
      deriv_state = d[31:0];
      prev_error  = err[31:0];
      prev_sensed = sensed;
      return drv[31:0];
   endfunction

   function automatic int draw_gap(input int mode);
      int gap;
      gap = 0;
      if (mode == 1) begin
         if ($urandom_range(0, 3) == 0) begin
            gap = $urandom_range(0, 13);
         end
      end else if (mode >= 2) begin
         gap = $urandom_range(0, 13);
      end
      return gap;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_drive.push_back(pid_predict_drive(req_target, req_sensed));
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0) begin
               req_valid  <= 1'b1;
               req_target <= pending_words[0].target;
               req_sensed <= pending_words[0].sensed;
               void'(pending_words.pop_front());
               send_gap   <= draw_gap(send_mode);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_wait <= 0;
      end else begin
         recv_next = recv_wait;
         if (rsp_valid && rsp_ready) begin
            if (predicted_drive.size() == 0) begin
               report_mismatch($sformatf("drive word %0d with no prediction pending",
                                         rsp_drive));
            end else if (rsp_drive !== predicted_drive[0]) begin
               report_mismatch($sformatf("drive %0d, predicted %0d",
                                         rsp_drive, predicted_drive[0]));
               void'(predicted_drive.pop_front());
            end else begin
               void'(predicted_drive.pop_front());
            end
            recv_next = draw_gap(recv_mode);
         end else if (recv_next > 0) begin
            recv_next = recv_next - 1;
         end
         recv_wait <= recv_next;
         rsp_ready <= (recv_next == 0) && !rsp_hold;
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("pid_controller_step regression: fail");
      $finish;
   end

   task automatic set_reg(input logic [2:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      case (idx)
         CSR_KP:            gain_p        = value;
         CSR_KI:            gain_i        = value;
         CSR_KD:            gain_d        = value;
         CSR_FILTER_TIME:   tau_q         = value[30:0];
         CSR_SAMPLE_PERIOD: period_q      = value[30:0];
         CSR_OUT_MIN:       drive_floor   = value;
         CSR_OUT_MAX:       drive_ceiling = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (pending_words.size() != 0 || req_valid || predicted_drive.size() != 0);
   endtask

   function automatic void queue_word(input logic signed [31:0] target,
                                      input logic signed [31:0] sensed);
      setpoint_word_type w;
      w.target = target;
      w.sensed = sensed;
      pending_words.push_back(w);
   endfunction

   function automatic logic [31:0] pick_extreme();
      logic [31:0] v;
      case ($urandom_range(0, 4))
         0:       v = S32_MIN;
         1:       v = S32_MAX;
         2:       v = '0;
         3:       v = '1;
         default: v = 32'd1;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] pick_gain(input int max_whole);
      logic [31:0] v;
      case ($urandom_range(0, 7))
         0:       v = S32_MIN;
         1:       v = S32_MAX;
         2:       v = $urandom;
         3:       v = -$urandom_range(0, max_whole << 16);
         default: v = $urandom_range(0, max_whole << 16);
      endcase
      return v;
   endfunction

   function automatic logic [31:0] pick_time(input bit allow_zero);
      logic [31:0] v;
      case ($urandom_range(0, 6))
         0:       v = $urandom;
         1:       v = 32'h7FFF_FFFF;
         2:       v = allow_zero ? 32'd0 : 32'd1;
         default: v = $urandom_range(1, 65536);
      endcase
      return v;
   endfunction

   task automatic randomize_settings();
      logic [31:0] low_lim;
      logic [31:0] high_lim;
      set_reg(CSR_KP, pick_gain(4));
      set_reg(CSR_KI, pick_gain(16));
      set_reg(CSR_KD, pick_gain(1));
      set_reg(CSR_FILTER_TIME, pick_time(1'b1));
      set_reg(CSR_SAMPLE_PERIOD, pick_time(1'b0));
      case ($urandom_range(0, 4))
         0: begin
            low_lim  = S32_MIN;
            high_lim = S32_MAX;
         end
         1: begin
            low_lim  = $urandom;
            high_lim = $urandom;
         end
         default: begin
            low_lim  = -$urandom_range(0, 200 << 16);
            high_lim = $urandom_range(0, 200 << 16);
         end
      endcase
      set_reg(CSR_OUT_MIN, low_lim);
      set_reg(CSR_OUT_MAX, high_lim);
      if ($urandom_range(0, 3) == 0) begin
         set_reg(CSR_UNUSED, $urandom);
      end
   endtask

   task automatic queue_trajectory(input int count);
      int goal;
      int plant;
      int step_size;
      goal      = int'($urandom) >>> $urandom_range(4, 16);
      plant     = int'($urandom) >>> $urandom_range(4, 16);
      step_size = 1 << $urandom_range(4, 20);
      repeat (count) begin
         case ($urandom_range(0, 9))
            0: queue_word($urandom, $urandom);
            1: queue_word(pick_extreme(), pick_extreme());
            default: begin
               if ($urandom_range(0, 15) == 0) begin
                  goal = int'($urandom) >>> $urandom_range(0, 16);
               end
               plant = plant + ((goal - plant) >>> 3)
                       + int'($urandom_range(0, 2 * step_size)) - step_size;
               queue_word(goal, plant);
            end
         endcase
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      send_mode = 1;
      recv_mode = 1;
      queue_word(S32_MAX, S32_MIN);
      queue_word(S32_MIN, S32_MAX);
      queue_word(0, 0);
      queue_word(S32_MAX, S32_MAX);
      queue_word(S32_MIN, S32_MIN);
      queue_word(32'sd65536, -32'sd65536);
      queue_word(-32'sd1, 32'sd0);
      wait_idle();

      set_reg(CSR_KP, S32_MIN);
      set_reg(CSR_KI, S32_MAX);
      set_reg(CSR_KD, S32_MAX);
      set_reg(CSR_FILTER_TIME, 32'h7FFF_FFFF);
      set_reg(CSR_SAMPLE_PERIOD, 32'h7FFF_FFFF);
      set_reg(CSR_OUT_MIN, S32_MIN);
      set_reg(CSR_OUT_MAX, S32_MAX);
      @(negedge clock);
      queue_word(S32_MAX, S32_MIN);
      queue_word(S32_MIN, S32_MAX);
      queue_word(0, S32_MIN);
      queue_word(0, S32_MAX);
      queue_word(32'sd1, -32'sd1);
      wait_idle();

      // Filter time and sample period both zero leave the derivative at zero.
      set_reg(CSR_KP, S32_MAX);
      set_reg(CSR_KI, S32_MIN);
      set_reg(CSR_KD, S32_MIN);
      set_reg(CSR_FILTER_TIME, 32'h8000_0000);
      set_reg(CSR_SAMPLE_PERIOD, 32'd0);
      set_reg(CSR_UNUSED, 32'hFFFF_FFFF);
      @(negedge clock);
      queue_word(S32_MIN, 0);
      queue_word(0, S32_MIN);
      queue_word(32'sd123456, -32'sd654321);
      queue_word(S32_MAX, S32_MAX);
      wait_idle();

      // Crossed output limits.
      set_reg(CSR_KP, 32'sd65536);
      set_reg(CSR_KI, 32'sd65536);
      set_reg(CSR_KD, 32'sd65536);
      set_reg(CSR_FILTER_TIME, 32'd65536);
      set_reg(CSR_SAMPLE_PERIOD, 32'd655);
      set_reg(CSR_OUT_MIN, 32'sd6553600);
      set_reg(CSR_OUT_MAX, -32'sd6553600);
      @(negedge clock);
      queue_word(0, 0);
      queue_word(32'sd9000000, 0);
      queue_word(-32'sd9000000, 0);
      queue_word(S32_MAX, S32_MIN);
      wait_idle();

      for (int phase = 0; phase < 8; phase++) begin
         randomize_settings();
         @(negedge clock);
         send_mode = phase % 3;
         recv_mode = (phase + phase / 3) % 3;
         if (phase == 1) begin
            // The receiver stalls long enough for the block to back up its input.
            send_mode = 0;
            fork
               begin
                  @(posedge clock);
                  rsp_hold <= 1'b1;
                  repeat (HOLD_CYCLES) @(posedge clock);
                  rsp_hold <= 1'b0;
               end
            join_none
         end
         queue_trajectory(106);
         wait_idle();
      end

      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("pid_controller_step regression: pass");
      end else begin
         $display("pid_controller_step regression: fail");
      end
      $finish;
   end

endmodule

// ===== pid_controller_step.f =====
rtl/pid_pkg.sv
rtl/pid_mul.sv
rtl/pid_div.sv
rtl/pid_controller_step.sv
tb/testbench.sv
